// File: design/dfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfp_pkg
// Types and constants shared by the date-time field parser.
// ---------------------------------------------------------------------------
package dfp_pkg;

	// Stage codes carried in the result and in the parse state
	localparam logic [2:0] STG_IDLE = 3'd0;  // no digit seen yet
	localparam logic [2:0] STG_YEAR = 3'd1;  // year field in progress
	localparam logic [2:0] STG_MON  = 3'd2;  // first of the 8-bit fields
	localparam logic [2:0] STG_DAY  = 3'd3;
	localparam logic [2:0] STG_HOUR = 3'd4;
	localparam logic [2:0] STG_MIN  = 3'd5;
	localparam logic [2:0] STG_SEC  = 3'd6;  // last field
	localparam logic [2:0] STG_STOP = 3'd7;  // parsing ended

	localparam int unsigned NUM_SMALL = 5;   // month, day, hour, minute, second

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// One input beat
	typedef struct packed {
		logic [7:0] char_in;
		logic       last;
	} char_beat_t;

	// One result beat
	typedef struct packed {
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [2:0]  stage;
	} field_beat_t;

endpackage

// File: design/datetime_field_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// datetime_field_parser_unit
// Byte-serial parser for year-month-dayThour:minute:second values.
// ---------------------------------------------------------------------------
// Usage:
//   char channel : one byte per beat (char_beat), last marks the final byte
//                  of a value. Accepted when char_valid && !char_stall.
//   field channel: one result beat per value, with year, month, day, hour,
//                  minute, second and the stage code. Accepted when
//                  field_valid && !field_stall.
// Order: an accepted byte waits in the input register, then is applied to the
//   parse state; a last byte loads the result register and clears the state.
// Throughput: one byte per cycle while char_stall is low. The limit is the
//   parse state update (one decimal multiply-add with saturation per byte).
// Stall: non-last bytes keep flowing while a result waits. A last byte waits
//   in the input register until the result register is free, and char_stall
//   is raised while it waits.
// Reset: arst_n clears the parse state and both valid flags; the block
//   accepts bytes as soon as reset is released.
// ---------------------------------------------------------------------------
module datetime_field_parser_unit
	import dfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  char_beat_t  char_beat,
	output logic        field_valid,
	input  logic        field_stall,
	output field_beat_t field_beat
);

	// Input register
	logic       valid_s1;
	char_beat_t beat_s1;

	// Parse state
	logic [2:0]  stage_q;
	logic [15:0] year_q;
	logic [7:0]  small_q [NUM_SMALL];

	// Result register
	logic        field_valid_q;
	field_beat_t field_q;

	// Next state
	logic [2:0]  stage_n;
	logic [15:0] year_n;
	logic [7:0]  small_n [NUM_SMALL];
	logic        is_digit;
	logic [3:0]  digit;
	logic [2:0]  st_eff;
	logic [2:0]  sidx;
	logic [7:0]  sep_ch;
	logic        out_free;
	logic        s1_go;
	logic        s1_fire;
	logic        in_acc;
	logic        out_load;

	// Decimal step with saturation
	function automatic logic [15:0] dec16(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
		return (v > 20'hffff) ? 16'hffff : v[15:0];
	endfunction

	function automatic logic [7:0] dec8(input logic [7:0] acc, input logic [3:0] d);
		logic [11:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, d};
		return (v > 12'h0ff) ? 8'hff : v[7:0];
	endfunction

	// Separator expected after each field up to the minute
	always_comb begin
		unique case (stage_q)
			STG_YEAR, STG_MON: sep_ch = CH_DASH;
			STG_DAY:           sep_ch = CH_T;
			STG_HOUR, STG_MIN: sep_ch = CH_COLON;
			default:           sep_ch = CH_SPACE;
		endcase
	end

	// Handshake control
	assign out_free   = !field_valid_q || !field_stall;
	assign s1_go      = !beat_s1.last || out_free;
	assign s1_fire    = valid_s1 && s1_go;
	assign char_stall = valid_s1 && !s1_go;
	assign in_acc     = char_valid && !char_stall;
	assign out_load   = s1_fire && beat_s1.last;

	// Per-byte parse step
	assign is_digit = (beat_s1.char_in >= CH_ZERO) && (beat_s1.char_in <= CH_NINE);
	assign digit    = beat_s1.char_in[3:0];
	assign st_eff   = (stage_q == STG_IDLE) ? STG_YEAR : stage_q;
	assign sidx     = st_eff - STG_MON;

	always_comb begin
		stage_n = stage_q;
		year_n  = year_q;
		small_n = small_q;
		if (stage_q != STG_STOP) begin
			if (is_digit) begin
				stage_n = st_eff;
				if (st_eff == STG_YEAR) begin
					year_n = dec16(year_q, digit);
				end else begin
					small_n[sidx] = dec8(small_q[sidx], digit);
				end
			end else if (stage_q != STG_IDLE) begin
				stage_n = (beat_s1.char_in == sep_ch && stage_q != STG_SEC) ?
					stage_q + 3'd1 : STG_STOP;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			beat_s1 <= char_beat;
		end
	end

	// Parse state; cleared after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_IDLE;
			year_q  <= '0;
			for (int i = 0; i < NUM_SMALL; i++) begin
				small_q[i] <= '0;
			end
		end else if (s1_fire) begin
			if (beat_s1.last) begin
				stage_q <= STG_IDLE;
				year_q  <= '0;
				for (int i = 0; i < NUM_SMALL; i++) begin
					small_q[i] <= '0;
				end
			end else begin
				stage_q <= stage_n;
				year_q  <= year_n;
				small_q <= small_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_valid_q <= 1'b0;
		end else if (out_load) begin
			field_valid_q <= 1'b1;
		end else if (!field_stall) begin
			field_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			field_q.year   <= year_n;
			field_q.month  <= small_n[0];
			field_q.day    <= small_n[1];
			field_q.hour   <= small_n[2];
			field_q.minute <= small_n[3];
			field_q.second <= small_n[4];
			field_q.stage  <= stage_n;
		end
	end

	assign field_valid = field_valid_q;
	assign field_beat  = field_q;

	// Checks
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (stage_q == STG_IDLE) && (year_q == 16'd0))
		else $error("parse state not cleared after last byte");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !beat_s1.last && stage_q == STG_STOP) |=> (stage_q == STG_STOP))
		else $error("stopped parse resumed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && beat_s1.last && field_valid_q && field_stall))
		else $error("input stalled without a blocked result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(field_valid) |-> $past(out_load))
		else $error("result appeared without a last byte");

endmodule
